// ----- rtl/tbaem_pkg.sv -----
// Package for the three-band audio energy meter: shared types and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tbaem_pkg;

  // Request opcodes on the input channel.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_WINDOW_LEN    = 3'd0;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [2:0] REG_LOW_B0        = 3'd2;
  localparam logic [2:0] REG_LOW_A1        = 3'd3;
  localparam logic [2:0] REG_LOW_A2        = 3'd4;
  localparam logic [2:0] REG_HIGH_B0       = 3'd5;
  localparam logic [2:0] REG_HIGH_A1       = 3'd6;
  localparam logic [2:0] REG_HIGH_A2       = 3'd7;

  localparam int COEF_W = 25;
  localparam int Y_W    = 26;
  localparam int SUM_W  = 48;

  localparam logic signed [Y_W-1:0] Y_MAX = 26'sh1FFFFFF;
  localparam logic signed [Y_W-1:0] Y_MIN = -26'sh2000000;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Input request payload.
  typedef struct packed {
    logic        op;
    logic [15:0] sample;
    logic        channel;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic [15:0] low_rms;
    logic [15:0] mid_rms;
    logic [15:0] high_rms;
    logic [15:0] envelope_rms;
    logic [15:0] peak_level;
    logic        partial;
  } out_res_t;

  // Configuration write payload.
  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_req_t;

  // Classified command passed from the front part to the back part.
  typedef struct packed {
    logic        flush;
    logic signed [15:0] sample;
    logic        channel;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/tbaem_if.sv -----
// Valid/ready channel interfaces for the three-band audio energy meter.
// Depends on tbaem_pkg for the payload types.
`default_nettype none

interface tbaem_in_if import tbaem_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbaem_out_if import tbaem_pkg::*; ();
  logic     valid;
  logic     ready;
  out_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbaem_cfg_if import tbaem_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tbaem_front.sv -----
// Front part: accepts requests, drops samples of inactive channels and
// queues the rest as commands. Depends on tbaem_pkg.
`default_nettype none

module tbaem_front
  import tbaem_pkg::*;
#(
  parameter int MAX_CHANNELS = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_req_t    in_data,
  input  wire logic [1:0] channel_count,
  output logic            cmd_valid,
  input  wire logic       cmd_ready,
  output cmd_t            cmd_data
);

  localparam int DEPTH = 2;

  cmd_t       queue [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [3:0] active;
  logic       keep;
  logic       push;
  logic       pop;

  // Clamp the channel count into the supported range; zero acts as one.
  always_comb begin
    active = {2'b00, channel_count};
    if (active == 4'd0) active = 4'd1;
    if (active > 4'(MAX_CHANNELS)) active = 4'(MAX_CHANNELS);
  end

  assign keep      = (in_data.op == OP_FLUSH) || ({3'b000, in_data.channel} < active);
  assign in_ready  = (fill != 2'(DEPTH));
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{flush:   (in_data.op == OP_FLUSH),
                         sample:  in_data.sample,
                         channel: in_data.channel};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tbaem_sqrt.sv -----
// Iterative integer square root with an up-front restoring divide by the
// window count; a new start is ignored until the root is done. Depends on tbaem_pkg.
`default_nettype none

module tbaem_sqrt
  import tbaem_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] sum,
  input  wire logic [15:0]      count,
  output logic                  done,
  output logic [15:0]           root
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SQRT = 2'd2;

  logic [1:0]       state;
  logic [5:0]       step;
  logic [SUM_W-1:0] quot;
  logic [16:0]      rem;
  logic [16:0]      rem_sh;
  logic [SUM_W-1:0] val;
  logic [SUM_W-1:0] res;
  logic [SUM_W-1:0] bitv;
  logic [SUM_W-1:0] trial;

  // One quotient bit per cycle.
  assign rem_sh = {rem[15:0], quot[SUM_W-1]};
  assign trial  = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            quot  <= sum;
            rem   <= '0;
            step  <= 6'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, count}) begin
            rem  <= rem_sh - {1'b0, count};
            quot <= {quot[SUM_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[SUM_W-2:0], 1'b0};
          end
          if (step == 6'(SUM_W - 1)) begin
            state <= S_SQRT;
            step  <= 6'd0;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_SQRT: begin
          if (step == 6'd0) begin
            val  <= quot;
            res  <= '0;
            bitv <= {2'b01, {(SUM_W-2){1'b0}}};
            step <= 6'd1;
          end else if (bitv == '0) begin
            root  <= (res > 48'd65535) ? 16'hFFFF : res[15:0];
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (val >= trial) begin
              val <= val - trial;
              res <= (res >> 1) + bitv;
            end else begin
              res <= res >> 1;
            end
            bitv <= bitv >> 2;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tbaem_back.sv -----
// Back part: runs both biquads on one shared multiplier, accumulates the
// window and produces results. Depends on tbaem_pkg and tbaem_sqrt.
`default_nettype none

module tbaem_back
  import tbaem_pkg::*;
#(
  parameter int MAX_CHANNELS   = 2,
  parameter int COEF_FRAC_BITS = 22
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  wire cmd_t                cmd_data,
  input  wire logic [15:0]         window_len,
  input  wire logic [COEF_W-1:0]   low_b0,
  input  wire logic [COEF_W-1:0]   low_a1,
  input  wire logic [COEF_W-1:0]   low_a2,
  input  wire logic [COEF_W-1:0]   high_b0,
  input  wire logic [COEF_W-1:0]   high_a1,
  input  wire logic [COEF_W-1:0]   high_a2,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_res_t                 out_data
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ACC_W = 64;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_ROUND = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_ROOT  = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_CLEAR = 4'd11;

  // Filter history: per channel and filter, x1, x2, y1, y2.
  logic signed [15:0]    hx1 [MAX_CHANNELS][2];
  logic signed [15:0]    hx2 [MAX_CHANNELS][2];
  logic signed [Y_W-1:0] hy1 [MAX_CHANNELS][2];
  logic signed [Y_W-1:0] hy2 [MAX_CHANNELS][2];

  logic [3:0]            state;
  logic                  filt;
  logic [1:0]            sq_idx;
  logic [1:0]            root_idx;
  logic [CH_W-1:0]       ch;
  logic signed [15:0]    x;
  logic signed [ACC_W-1:0] acc;
  logic signed [Y_W-1:0] yl;
  logic signed [Y_W-1:0] yh;
  logic [SUM_W-1:0]      sq;
  logic [SUM_W-1:0]      sum_low;
  logic [SUM_W-1:0]      sum_mid;
  logic [SUM_W-1:0]      sum_high;
  logic [SUM_W-1:0]      sum_in;
  logic [15:0]           peak;
  logic [15:0]           count;
  logic                  partial;
  logic [15:0]           roots [4];
  logic [CH_W:0]         clr_ch;

  // Shared multiplier operands.
  logic signed [COEF_W-1:0] m_a;
  logic signed [Y_W+1:0]    m_b;
  logic signed [52:0]       m_p;
  logic signed [COEF_W-1:0] cb0, ca1, ca2;
  logic signed [Y_W+1:0]    xsum;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  ysh;
  logic signed [Y_W+1:0]    band;
  logic [Y_W+1:0]           mag;
  logic [15:0]              ax;
  logic [SUM_W:0]           add_in;
  logic [SUM_W-1:0]         add_a;
  logic                     sq_start;
  logic [SUM_W-1:0]         sq_sum;
  logic                     sq_done;
  logic [15:0]              sq_root;

  assign cb0 = filt ? $signed(high_b0) : $signed(low_b0);
  assign ca1 = filt ? $signed(high_a1) : $signed(low_a1);
  assign ca2 = filt ? $signed(high_a2) : $signed(low_a2);
  assign xsum = (Y_W+2)'(x) + ((Y_W+2)'(hx1[ch][filt]) <<< 1) + (Y_W+2)'(hx2[ch][filt]);

  // Operand selection for the multiplier by step.
  always_comb begin
    m_a = cb0;
    m_b = xsum;
    case (state)
      S_MUL1: begin
        m_a = ca1;
        m_b = (Y_W+2)'(hy1[ch][filt]);
      end
      S_MUL2: begin
        m_a = ca2;
        m_b = (Y_W+2)'(hy2[ch][filt]);
      end
      default: begin
        m_a = cb0;
        m_b = xsum;
      end
    endcase
  end
  assign m_p = 53'(m_a) * 53'(m_b);

  // Rounded filter output; saturation follows in S_ROUND.
  assign rnd = acc + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
  assign ysh = rnd >>> COEF_FRAC_BITS;

  // Band value for the square step.
  always_comb begin
    case (sq_idx)
      2'd0:    band = (Y_W+2)'(yl);
      2'd1:    band = (Y_W+2)'(yh) - (Y_W+2)'(yl);
      2'd2:    band = ((Y_W+2)'(x) <<< 8) - (Y_W+2)'(yh);
      default: band = (Y_W+2)'(x);
    endcase
    mag = band[Y_W+1] ? (Y_W+2)'(-band) : band;
  end
  assign ax = x[15] ? 16'(-x) : 16'(x);

  // Square on its own multiplier: narrow enough for one 28 by 28 product.
  logic [55:0] sq_full;
  assign sq_full = 56'(mag) * 56'(mag);

  always_comb begin
    case (sq_idx)
      2'd0:    add_a = sum_low;
      2'd1:    add_a = sum_mid;
      2'd2:    add_a = sum_high;
      default: add_a = sum_in;
    endcase
    add_in = {1'b0, add_a} + {1'b0, sq};
  end

  always_comb begin
    case (root_idx)
      2'd0:    sq_sum = sum_low;
      2'd1:    sq_sum = sum_mid;
      2'd2:    sq_sum = sum_high;
      default: sq_sum = sum_in;
    endcase
  end

  tbaem_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .sum   (sq_sum),
    .count (count),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign sq_start  = (state == S_ROOT);
  assign cmd_ready = (state == S_IDLE) && !out_valid;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ch    <= '0;
      out_valid <= 1'b0;
      sum_low   <= '0;
      sum_mid   <= '0;
      sum_high  <= '0;
      sum_in    <= '0;
      peak      <= '0;
      count     <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          for (int f = 0; f < 2; f++) begin
            hx1[clr_ch[CH_W-1:0]][f] <= '0;
            hx2[clr_ch[CH_W-1:0]][f] <= '0;
            hy1[clr_ch[CH_W-1:0]][f] <= '0;
            hy2[clr_ch[CH_W-1:0]][f] <= '0;
          end
          if (clr_ch == (CH_W+1)'(MAX_CHANNELS - 1)) state <= S_IDLE;
          clr_ch <= clr_ch + (CH_W+1)'(1);
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            x  <= cmd_data.sample;
            ch <= CH_W'(cmd_data.channel);
            filt <= 1'b0;
            if (cmd_data.flush) begin
              partial <= 1'b1;
              clr_ch  <= '0;
              if (count != 16'd0) begin
                root_idx <= 2'd0;
                state    <= S_ROOT;
              end else begin
                state <= S_CLEAR;
              end
            end else begin
              partial <= 1'b0;
              state   <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          acc   <= ACC_W'(m_p) <<< 8;
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc   <= acc - ACC_W'(m_p);
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= acc - ACC_W'(m_p);
          state <= S_ROUND;
        end
        S_ROUND: begin
          logic signed [Y_W-1:0] y;
          y = (ysh > ACC_W'(Y_MAX)) ? Y_MAX :
              (ysh < ACC_W'(Y_MIN)) ? Y_MIN : ysh[Y_W-1:0];
          hx2[ch][filt] <= hx1[ch][filt];
          hx1[ch][filt] <= x;
          hy2[ch][filt] <= hy1[ch][filt];
          hy1[ch][filt] <= y;
          if (filt) begin
            yh     <= y;
            sq_idx <= 2'd0;
            state  <= S_SQ;
          end else begin
            yl    <= y;
            filt  <= 1'b1;
            state <= S_MUL0;
          end
        end
        S_SQ: begin
          // The input square is x^2 * 4; band squares drop 14 bits.
          if (sq_idx == 2'd3) sq <= SUM_W'(sq_full << 2);
          else sq <= SUM_W'(sq_full >> 14);
          state <= S_ACC;
        end
        S_ACC: begin
          logic [SUM_W-1:0] s;
          s = add_in[SUM_W] ? SUM_MAX : add_in[SUM_W-1:0];
          case (sq_idx)
            2'd0:    sum_low  <= s;
            2'd1:    sum_mid  <= s;
            2'd2:    sum_high <= s;
            default: sum_in   <= s;
          endcase
          if (sq_idx == 2'd3) begin
            if (ax > peak) peak <= ax;
            count <= (count == 16'hFFFF) ? 16'hFFFF : count + 16'd1;
            state <= S_CHECK;
          end else begin
            sq_idx <= sq_idx + 2'd1;
            state  <= S_SQ;
          end
        end
        S_CHECK: begin
          if (count >= window_len) begin
            root_idx <= 2'd0;
            state    <= S_ROOT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ROOT: state <= S_WAIT;
        S_WAIT: begin
          if (sq_done) begin
            roots[root_idx] <= sq_root;
            if (root_idx == 2'd3) begin
              state <= S_EMIT;
            end else begin
              root_idx <= root_idx + 2'd1;
              state    <= S_ROOT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_data <= '{low_rms: roots[0], mid_rms: roots[1],
                          high_rms: roots[2], envelope_rms: roots[3],
                          peak_level: peak, partial: partial};
            out_valid <= 1'b1;
            sum_low   <= '0;
            sum_mid   <= '0;
            sum_high  <= '0;
            sum_in    <= '0;
            peak      <= '0;
            count     <= '0;
            state     <= partial ? S_CLEAR : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/three_band_audio_energy_meter_unit.sv -----
// Three-band audio energy meter, top level.
// Channels: "in" takes requests (op, sample, channel) on valid/ready;
// "out" delivers one result per closed window on valid/ready; "cfg" writes
// the eight registers (window_len, channel_count, six coefficients).
// A sample runs both biquads of its channel on one shared multiplier, three
// products and a rounding step per filter, then four square-and-accumulate
// steps and a window check, after the step that accepts it. A closing window
// adds four divide-and-root passes, each a bit-serial divide by the sample
// count, a bit-serial square root and a hand-over, and then an emit step.
// A two-entry request queue sits between the front and back parts, so
// requests are taken while the back part works or a result waits.
// Reset restores the register defaults and clears the window; the filter
// history is swept to zero channel by channel, during which the back
// part takes no command. End of stream sweeps it the same way.
// When the receiver stalls, the result is held and the back part takes no
// new command until it leaves; the queue then fills and in.ready drops.
`default_nettype none

module three_band_audio_energy_meter_unit
  import tbaem_pkg::*;
#(
  parameter int MAX_CHANNELS   = 2,
  parameter int COEF_FRAC_BITS = 22
) (
  input wire logic     clk,
  input wire logic     rst,
  tbaem_in_if.sink     in,
  tbaem_out_if.source  out,
  tbaem_cfg_if.sink    cfg
);

  logic [15:0]       window_len;
  logic [1:0]        channel_count;
  logic [COEF_W-1:0] low_b0, low_a1, low_a2, high_b0, high_a1, high_a2;
  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd_data;

  assign cfg.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= 16'd2205;
      channel_count <= 2'd2;
      low_b0        <= 25'sd1298;
      low_a1        <= -25'sd8177374;
      low_a2        <= 25'sd3988259;
      high_b0       <= 25'sd292670;
      high_a1       <= -25'sd4724613;
      high_a2       <= 25'sd1701002;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_WINDOW_LEN:    window_len    <= cfg.data.data[15:0];
        REG_CHANNEL_COUNT: channel_count <= cfg.data.data[1:0];
        REG_LOW_B0:        low_b0        <= cfg.data.data[COEF_W-1:0];
        REG_LOW_A1:        low_a1        <= cfg.data.data[COEF_W-1:0];
        REG_LOW_A2:        low_a2        <= cfg.data.data[COEF_W-1:0];
        REG_HIGH_B0:       high_b0       <= cfg.data.data[COEF_W-1:0];
        REG_HIGH_A1:       high_a1       <= cfg.data.data[COEF_W-1:0];
        REG_HIGH_A2:       high_a2       <= cfg.data.data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  tbaem_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in.valid),
    .in_ready      (in.ready),
    .in_data       (in.data),
    .channel_count (channel_count),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd_data      (cmd_data)
  );

  tbaem_back #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .window_len (window_len),
    .low_b0     (low_b0),
    .low_a1     (low_a1),
    .low_a2     (low_a2),
    .high_b0    (high_b0),
    .high_a1    (high_a1),
    .high_a2    (high_a2),
    .out_valid  (out.valid),
    .out_ready  (out.ready),
    .out_data   (out.data)
  );

endmodule

`default_nettype wire

// ----- rtl/tbaem_checker.sv -----
// Port-level checker for the three-band audio energy meter, with its bind.
// Depends on tbaem_pkg and the top level's interface ports.
`default_nettype none

module tbaem_checker
  import tbaem_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire out_res_t out_data,
  input wire logic     cfg_ready
);

  // A result that waits keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // Peak never exceeds full-scale magnitude.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.peak_level <= 16'h8000)
    else $error("peak out of range");

  // No result is shown right after reset.
  assert property (@(posedge clk) $fell(rst) |-> !out_valid)
    else $error("result after reset");

  // Configuration writes are always taken.
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration stalled");

endmodule

bind three_band_audio_energy_meter_unit tbaem_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .out_data  (out.data),
  .cfg_ready (cfg.ready)
);

`default_nettype wire
